/* src/ycr_pkg.sv */
// Shared widths and fixed-point constants for the YCbCr 6:4:4 to RGB565 converter.
package ycr_pkg;

   // Field widths of the input and result items.
   localparam int LUMA_W   = 6;
   localparam int CHROMA_W = 4;
   localparam int PIXEL_W  = 16;

   // Signed chroma offset after removing the mid code (-8..7).
   localparam int DCHROMA_W = CHROMA_W + 1;

   // Accumulator width of one channel sum and its fraction bits.
   localparam int ACC_W  = 27;
   localparam int FRAC_W = 16;
   localparam int CHAN_W = ACC_W - FRAC_W;

   // Chroma mid point expressed as a 4-bit code (128 / 16).
   localparam logic [DCHROMA_W-1:0] CHROMA_MID_CODE = DCHROMA_W'(8);

   // Q16 conversion coefficients.
   localparam logic signed [ACC_W-1:0] COEF_R_CR = ACC_W'(91881);
   localparam logic signed [ACC_W-1:0] COEF_G_CB = ACC_W'(22554);
   localparam logic signed [ACC_W-1:0] COEF_G_CR = ACC_W'(46802);
   localparam logic signed [ACC_W-1:0] COEF_B_CB = ACC_W'(116130);

endpackage

/* src/ycr_req_chan.sv */
// Channel interfaces for the pixel converter: the YCbCr request and the RGB565 response.
interface ycr_req_chan
   import ycr_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [LUMA_W-1:0]   luma;
   logic [CHROMA_W-1:0] chroma_blue;
   logic [CHROMA_W-1:0] chroma_red;

   modport source (output valid, output luma, output chroma_blue, output chroma_red,
                   input ready);
   modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                   output ready);
endinterface

interface ycr_rsp_chan
   import ycr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_565;

   modport source (output valid, output pixel_565, input ready);
   modport sink   (input valid, input pixel_565, output ready);
endinterface

/* src/ycbcr644_to_rgb565_unit.sv */
// Top level of the YCbCr 6:4:4 to RGB565 pixel converter.
//
//   Channel    Direction  Payload                              Handshake
//   req_chan   in         luma[5:0], chroma_blue, chroma_red   valid/ready
//   rsp_chan   out        pixel_565[15:0]                      valid/ready
//
// Each item passes an input register and then a result register, which offers
// its result; a new item is taken every cycle while the request side is ready.
// The conversion (four constant products, the channel sums, a clamp) sits between them.
// Reset clears both valid flags only. A stall on the response side backs up
// through the two registers, and the request side stays ready while either
// register can still move.
module ycbcr644_to_rgb565_unit
   import ycr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   ycr_req_chan.sink   req_chan,
   ycr_rsp_chan.source rsp_chan
);

   // Saturate one signed channel value to 0..255.
   function automatic logic [7:0] clamp_u8(input logic signed [CHAN_W-1:0] v);
      logic [7:0] res;
      if (v[CHAN_W-1]) begin
         res = 8'd0;
      end else if (|v[CHAN_W-2:8]) begin
         res = 8'hFF;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   logic                in_valid_ff;
   logic [LUMA_W-1:0]   luma_ff;
   logic [CHROMA_W-1:0] cb_ff;
   logic [CHROMA_W-1:0] cr_ff;
   logic                out_valid_ff;
   logic [PIXEL_W-1:0]  pixel_ff;
   logic [PIXEL_W-1:0]  pixel_in;

   logic out_open;
   logic in_open;

   logic signed [DCHROMA_W-1:0] dcb;
   logic signed [DCHROMA_W-1:0] dcr;
   logic signed [ACC_W-1:0]     dcb_ext;
   logic signed [ACC_W-1:0]     dcr_ext;
   logic signed [ACC_W-1:0]     y_base;
   logic signed [ACC_W-1:0]     acc_r;
   logic signed [ACC_W-1:0]     acc_g;
   logic signed [ACC_W-1:0]     acc_b;
   logic [7:0]                  red;
   logic [7:0]                  green;
   logic [7:0]                  blue;

   // Flow control: each register can load when empty or when it drains.
   assign out_open       = !out_valid_ff || rsp_chan.ready;
   assign in_open        = !in_valid_ff || out_open;
   assign req_chan.ready = in_open;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_open) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_open && req_chan.valid) begin
         luma_ff <= req_chan.luma;
         cb_ff   <= req_chan.chroma_blue;
         cr_ff   <= req_chan.chroma_red;
      end
   end

   // Chroma offsets in units of 16 and the Q16 luma base.
   always_comb begin
      dcb     = $signed({1'b0, cb_ff}) - $signed(CHROMA_MID_CODE);
      dcr     = $signed({1'b0, cr_ff}) - $signed(CHROMA_MID_CODE);
      dcb_ext = {{(ACC_W-DCHROMA_W){dcb[DCHROMA_W-1]}}, dcb};
      dcr_ext = {{(ACC_W-DCHROMA_W){dcr[DCHROMA_W-1]}}, dcr};
      y_base  = $signed({{(ACC_W-LUMA_W-2-FRAC_W){1'b0}}, luma_ff, 2'b00,
                         {FRAC_W{1'b0}}});
   end

   // Channel sums; the chroma scale of 16 is a shift after the product.
   always_comb begin
      acc_r = y_base + ((COEF_R_CR * dcr_ext) <<< 4);
      acc_g = y_base - ((COEF_G_CB * dcb_ext) <<< 4) - ((COEF_G_CR * dcr_ext) <<< 4);
      acc_b = y_base + ((COEF_B_CB * dcb_ext) <<< 4);
   end

   // Floor by dropping the fraction, clamp, and pack as 5:6:5.
   always_comb begin
      red      = clamp_u8(acc_r[ACC_W-1:FRAC_W]);
      green    = clamp_u8(acc_g[ACC_W-1:FRAC_W]);
      blue     = clamp_u8(acc_b[ACC_W-1:FRAC_W]);
      pixel_in = {red[7:3], green[7:2], blue[7:3]};
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= in_valid_ff;
      end
      if (out_open && in_valid_ff) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pixel_565 = pixel_ff;

endmodule

/* tb/ycbcr644_to_rgb565_unit_test.sv */
// Self-checking testbench for the YCbCr 6:4:4 to RGB565 pixel converter.
module ycbcr644_to_rgb565_unit_test
   import ycr_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   // Q16 conversion factors and the chroma mid point of the 8-bit samples.
   localparam int RED_PER_CR   = 91881;
   localparam int GREEN_PER_CB = 22554;
   localparam int GREEN_PER_CR = 46802;
   localparam int BLUE_PER_CB  = 116130;
   localparam int CHROMA_ZERO  = 128;

   // Run length, run limit, the window without random idling, the response hold-off and the drain.
   localparam int RANDOM_PIXELS = 1700;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int CALM_FIRST    = 800;
   localparam int CALM_LAST     = 1400;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 4;

   typedef struct packed {
      logic [LUMA_W-1:0]   luma;
      logic [CHROMA_W-1:0] chroma_blue;
      logic [CHROMA_W-1:0] chroma_red;
   } ycbcr_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ycr_req_chan req_chan ();
   ycr_rsp_chan rsp_chan ();

   ycbcr_pixel_type    pending_pixels[$];
   logic [PIXEL_W-1:0] expected_rgb565[$];
   ycbcr_pixel_type    next_pixel;
   logic               req_taken = 1'b0;
   int                 cycle_count = 0;
   int                 hold_left = 0;
   int                 error_count = 0;

   ycbcr644_to_rgb565_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Free-running clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Saturates one converted channel to the 8-bit range.
   function automatic logic [7:0] saturate_u8(int value);
      if (value < 0) begin
         return 8'd0;
      end
      if (value > 255) begin
         return 8'd255;
      end
      return value[7:0];
   endfunction

   // Expands the reduced codes, converts in Q16, floors, clamps and packs as RGB565.
   function automatic logic [PIXEL_W-1:0] rgb565_of(ycbcr_pixel_type px);
      int         luma_q16;
      int         cb_offset;
      int         cr_offset;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      luma_q16  = int'(px.luma) * 4 * 65536;
      cb_offset = int'(px.chroma_blue) * 16 - CHROMA_ZERO;
      cr_offset = int'(px.chroma_red) * 16 - CHROMA_ZERO;
      red   = saturate_u8((luma_q16 + RED_PER_CR * cr_offset) >>> 16);
      green = saturate_u8((luma_q16 - GREEN_PER_CB * cb_offset
                           - GREEN_PER_CR * cr_offset) >>> 16);
      blue  = saturate_u8((luma_q16 + BLUE_PER_CB * cb_offset) >>> 16);
      return {red[7:3], green[7:2], blue[7:3]};
   endfunction

   // Random idling on either side, switched off inside the calm window.
   function automatic bit take_break();
      if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) begin
         return 1'b0;
      end
      return $urandom_range(99) < 16;
   endfunction

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ycbcr644_to_rgb565_unit verification failed");
         $finish;
      end
   end

   // Predict the result of every accepted item.
   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_rgb565.push_back(rgb565_of({req_chan.luma, req_chan.chroma_blue,
                                              req_chan.chroma_red}));
      end
   end

   // Driver: offers the next pending item once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_pixels.size() != 0 && !take_break()) begin
            next_pixel = pending_pixels.pop_front();
            req_chan.luma        <= next_pixel.luma;
            req_chan.chroma_blue <= next_pixel.chroma_blue;
            req_chan.chroma_red  <= next_pixel.chroma_red;
            req_chan.valid       <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus two long hold-offs that back the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (cycle_count == 300 || cycle_count == 1600) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_CYCLES;
      end else begin
         rsp_chan.ready <= !take_break();
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rgb565.size() == 0) begin
            $error("unexpected result: pixel_565 actual %h", rsp_chan.pixel_565);
            error_count <= error_count + 1;
         end else if (expected_rgb565[0] !== rsp_chan.pixel_565) begin
            $error("pixel_565 mismatch: expected %h actual %h",
                   expected_rgb565[0], rsp_chan.pixel_565);
            error_count <= error_count + 1;
            void'(expected_rgb565.pop_front());
         end else begin
            void'(expected_rgb565.pop_front());
         end
      end
   end

   // Stimulus, reset, drain and final verdict.
   initial begin
      req_chan.valid       = 1'b0;
      req_chan.luma        = '0;
      req_chan.chroma_blue = '0;
      req_chan.chroma_red  = '0;
      rsp_chan.ready       = 1'b0;

      // Corners of all three fields, which drive every channel into both clamps.
      for (int i = 0; i < 8; i++) begin
         pending_pixels.push_back({i[2] ? 6'd63 : 6'd0, i[1] ? 4'd15 : 4'd0,
                                   i[0] ? 4'd15 : 4'd0});
      end
      // Neutral chroma and values near the clamp edges.
      pending_pixels.push_back({6'd0, 4'd8, 4'd8});
      pending_pixels.push_back({6'd32, 4'd8, 4'd8});
      pending_pixels.push_back({6'd63, 4'd8, 4'd8});
      pending_pixels.push_back({6'd63, 4'd7, 4'd7});
      pending_pixels.push_back({6'd1, 4'd9, 4'd9});
      pending_pixels.push_back({6'd40, 4'd15, 4'd8});
      pending_pixels.push_back({6'd20, 4'd0, 4'd8});
      pending_pixels.push_back({6'd20, 4'd8, 4'd15});
      pending_pixels.push_back({6'd40, 4'd8, 4'd0});

      // Random pixels over the full code space.
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         pending_pixels.push_back({6'($urandom_range(63)), 4'($urandom_range(15)),
                                   4'($urandom_range(15))});
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every item is taken and every result has been checked.
      while (pending_pixels.size() != 0 || req_chan.valid || expected_rgb565.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("ycbcr644_to_rgb565_unit verification clean");
      end else begin
         $display("ycbcr644_to_rgb565_unit verification failed");
      end
      $finish;
   end

endmodule
